// ===== hw/rtl/somr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the spiral order matrix reader.
// No dependencies; somr_walker and spiral_order_matrix_reader_unit import this package.

package somr_pkg;

    // Row and column positions carried on the result stream.
    localparam int POS_W = 3;
    // Width of the row_count and column_count registers.
    localparam int DIM_W = 4;
    // Configuration register index width and register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
    // Reset value of both dimension registers.
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd4;

    // One spiral position handed from the walker to the read pipeline.
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic             last;
    } somr_pos_t;

    // Force a dimension register into 1..max_dim.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] max_dim);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = {{(DIM_W-1){1'b0}}, 1'b1};
        else if (v > max_dim)
            r = max_dim;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== hw/rtl/somr_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module somr_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/somr_walker.sv =====
`timescale 1ns / 1ps
// Spiral walker: steps row/column through the matrix clockwise, ring by ring.
// Depends on somr_pkg.

module somr_walker #(
    parameter int MAX_DIM = 8,
    parameter int ADDR_W  = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [somr_pkg::DIM_W-1:0] rows,
    input  logic [somr_pkg::DIM_W-1:0] cols,
    input  logic                       advance,
    output logic                       busy,
    output somr_pkg::somr_pos_t        pos,
    output logic [ADDR_W-1:0]          rd_addr
);
    import somr_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int PROD_W = 2 * DIM_W;

    typedef enum logic [4:0] {
        W_IDLE  = 5'b00001,
        W_RIGHT = 5'b00010,
        W_DOWN  = 5'b00100,
        W_LEFT  = 5'b01000,
        W_UP    = 5'b10000
    } walk_state_t;

    walk_state_t      state_reg, state_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] top_reg, top_next;
    logic [POS_W-1:0] bot_reg, bot_next;
    logic [POS_W-1:0] left_reg, left_next;
    logic [POS_W-1:0] right_reg, right_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [DIM_W-1:0] cols_reg, cols_next;
    logic             last;
    logic [PROD_W-1:0] lin_addr;
    logic [PROD_W-1:0] dim_prod;
    logic [DIM_W-1:0]  rows_m1;
    logic [DIM_W-1:0]  cols_m1;

    assign dim_prod = PROD_W'(rows) * PROD_W'(cols);
    assign rows_m1  = rows - 1'b1;
    assign cols_m1  = cols - 1'b1;
    assign last     = (count_reg == total_reg - 1'b1);
    assign busy     = (state_reg != W_IDLE);
    assign lin_addr = PROD_W'(row_reg) * PROD_W'(cols_reg) + PROD_W'(col_reg);
    assign rd_addr  = lin_addr[ADDR_W-1:0];

    always_comb
    begin
        pos.row    = row_reg;
        pos.column = col_reg;
        pos.last   = last;
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        top_next   = top_reg;
        bot_next   = bot_reg;
        left_next  = left_reg;
        right_next = right_reg;
        count_next = count_reg;
        total_next = total_reg;
        cols_next  = cols_reg;
        unique case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    state_next = W_RIGHT;
                    row_next   = '0;
                    col_next   = '0;
                    top_next   = '0;
                    left_next  = '0;
                    bot_next   = rows_m1[POS_W-1:0];
                    right_next = cols_m1[POS_W-1:0];
                    count_next = '0;
                    total_next = dim_prod[CNT_W-1:0];
                    cols_next  = cols;
                end
            end
            W_RIGHT:
            begin
                if (advance)
                begin
                    if (col_reg == right_reg)
                    begin
                        top_next   = top_reg + 1'b1;
                        row_next   = row_reg + 1'b1;
                        state_next = W_DOWN;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            W_DOWN:
            begin
                if (advance)
                begin
                    if (row_reg == bot_reg)
                    begin
                        right_next = right_reg - 1'b1;
                        col_next   = col_reg - 1'b1;
                        state_next = W_LEFT;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            W_LEFT:
            begin
                if (advance)
                begin
                    if (col_reg == left_reg)
                    begin
                        bot_next   = bot_reg - 1'b1;
                        row_next   = row_reg - 1'b1;
                        state_next = W_UP;
                    end
                    else
                    begin
                        col_next = col_reg - 1'b1;
                    end
                end
            end
            W_UP:
            begin
                if (advance)
                begin
                    if (row_reg == top_reg)
                    begin
                        left_next  = left_reg + 1'b1;
                        col_next   = col_reg + 1'b1;
                        state_next = W_RIGHT;
                    end
                    else
                    begin
                        row_next = row_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
        // The element count ends the walk, whatever ring shape remains.
        if (busy && advance)
        begin
            count_next = count_reg + 1'b1;
            if (last)
            begin
                state_next = W_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        top_reg   <= top_next;
        bot_reg   <= bot_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        count_reg <= count_next;
        total_reg <= total_next;
        cols_reg  <= cols_next;
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg < total_reg))
        else $error("walker count passed the element total");

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && advance && last) |=> !busy)
        else $error("walker kept running after the last element");

endmodule

// ===== hw/rtl/spiral_order_matrix_reader_unit.sv =====
`timescale 1ns / 1ps
// Top level of the spiral order matrix reader: loader, element RAM, read pipeline.
// Depends on somr_pkg, somr_ram and somr_walker.
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  ----------------------------------
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: element_value
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: out_value,out_row,out_column
//                                                    tlast: final_flag
//  cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// Rates: one loaded element per cycle while no spiral is being walked, then one
//   emitted result per cycle while m_axis is not stalled; the single read port of
//   the element RAM sets the readout rate.
// Reset: row_count and column_count go to 4, the load position to 0. The element
//   RAM is not cleared; entries are read only after being written.
// Stalls: s_axis_tready drops while the spiral is being walked. A stalled m_axis
//   holds the output register and the RAM read stage, and the walker waits.

module spiral_order_matrix_reader_unit #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // element_value [DATA_WIDTH-1:0], zero padding above
    input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // out_value [DATA_WIDTH-1:0], out_row, out_column, zero padding above
    output logic [((DATA_WIDTH+2*somr_pkg::POS_W+7)/8)*8-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [somr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [somr_pkg::DIM_W-1:0]     cfg_data
);
    import somr_pkg::*;

    localparam int DEPTH       = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int PROD_W      = 2 * DIM_W;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + 2 * POS_W + 7) / 8) * 8;

    logic [DIM_W-1:0]      row_count_reg, row_count_next;
    logic [DIM_W-1:0]      column_count_reg, column_count_next;
    logic [ADDR_W-1:0]     load_pos_reg, load_pos_next;
    logic [DIM_W-1:0]      rows_eff;
    logic [DIM_W-1:0]      cols_eff;
    logic [PROD_W-1:0]     total_prod;
    logic [CNT_W-1:0]      total;
    logic [ADDR_W-1:0]     wr_pos;
    logic [CNT_W-1:0]      wr_pos_inc;
    logic                  in_fire;
    logic                  load_last;
    logic                  walk_start;
    logic                  walk_busy;
    logic                  issue;
    somr_pos_t             walk_pos;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  s1_valid_reg, s1_valid_next;
    somr_pos_t             s1_pos_reg;
    logic                  s1_move;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_value_reg;
    somr_pos_t             out_pos_reg;

    // Configuration: always ready; written only while idle, a user duty not enforced.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:    row_count_next    = cfg_data;
                REG_COLUMN_COUNT: column_count_next = cfg_data;
                default:          ;
            endcase
        end
    end

    assign rows_eff   = clamp_dim(row_count_reg, DIM_W'(MAX_DIM));
    assign cols_eff   = clamp_dim(column_count_reg, DIM_W'(MAX_DIM));
    assign total_prod = PROD_W'(rows_eff) * PROD_W'(cols_eff);
    assign total      = total_prod[CNT_W-1:0];

    // Loader: restart at zero if the size shrank under the load position.
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign wr_pos     = (CNT_W'(load_pos_reg) >= total) ? '0 : load_pos_reg;
    assign wr_pos_inc = CNT_W'(wr_pos) + 1'b1;
    assign load_last  = (wr_pos_inc >= total);
    assign walk_start = in_fire && load_last;

    always_comb
    begin
        load_pos_next = load_pos_reg;
        if (in_fire)
        begin
            load_pos_next = load_last ? '0 : wr_pos_inc[ADDR_W-1:0];
        end
    end

    // Hold off new elements while the spiral reads the RAM; the output side
    // may still be draining when loading resumes, since reads are already done.
    assign s_axis_tready = !walk_busy;

    somr_ram #(
        .WIDTH  (DATA_WIDTH),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (wr_pos),
        .wr_data (s_axis_tdata[DATA_WIDTH-1:0]),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    somr_walker #(
        .MAX_DIM (MAX_DIM),
        .ADDR_W  (ADDR_W)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (walk_start),
        .rows    (rows_eff),
        .cols    (cols_eff),
        .advance (issue),
        .busy    (walk_busy),
        .pos     (walk_pos),
        .rd_addr (rd_addr)
    );

    // Read pipeline: walker -> RAM read stage (s1) -> output register.
    // The RAM holds its read data while not enabled, so s1 needs no data copy.
    assign s1_move = !out_valid_reg || m_axis_tready;
    assign issue   = walk_busy && (!s1_valid_reg || s1_move);

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= DIM_RESET;
            column_count_reg <= DIM_RESET;
            load_pos_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            load_pos_reg     <= load_pos_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_pos_reg <= walk_pos;
        end
        if (s1_move && s1_valid_reg)
        begin
            out_value_reg <= rd_data;
            out_pos_reg   <= s1_pos_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_pos_reg.last;
    assign m_axis_tdata  = OUT_TDATA_W'({out_pos_reg.column, out_pos_reg.row, out_value_reg});

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        walk_start |-> !walk_busy)
        else $error("spiral start while a walk is in progress");

    a_out_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("result changed while the output was stalled");

    a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_axis_tready)
            |=> (s1_valid_reg && $stable(s1_pos_reg)))
        else $error("read stage lost its item under output stall");

    a_no_load_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> !in_fire)
        else $error("element write overlaps a spiral read");

endmodule

// ===== tb/sv/tb_spiral_order_matrix_reader_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for spiral_order_matrix_reader_unit: streams matrices in
// row-major order and checks the clockwise spiral readout against a local predictor.
// Depends on somr_pkg and the spiral_order_matrix_reader_unit RTL.

module tb_spiral_order_matrix_reader_unit;

    import somr_pkg::*;

    localparam int VALUE_W        = 32;
    localparam int M_TDATA_W      = ((VALUE_W + 2 * POS_W + 7) / 8) * 8;
    localparam int STORE_DEPTH    = 64;
    localparam int SLOT_W         = $clog2(STORE_DEPTH);
    localparam int DIM_MAX        = 8;
    localparam int DIRECTED_ROWS  = 27;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 12;
    localparam int PRESSURE_PHASE = 1;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 200000;

    // Index that maps to no register; a write there must leave both sizes alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [0:0] {ROW_ELEM, ROW_CFG} row_kind_t;

    // One spiral result as it leaves the block.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   column;
        logic               last;
    } spiral_result_t;

    // One line of the directed table: either an element or a register write.
    typedef struct packed {
        row_kind_t          kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [DIM_W-1:0]   reg_value;
        logic [VALUE_W-1:0] value;
        logic               typed;
        spiral_result_t     typed_result;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [VALUE_W-1:0]     s_axis_tdata = '0;      // element_value
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;           // out_value, out_row, out_column, pad
    logic                   m_axis_tlast;           // final_flag
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data = '0;

    // Typed expectation that travels alongside the element being offered.
    logic                   item_typed = 1'b0;
    spiral_result_t         item_typed_result = '0;

    // Predictor state: a copy of the element store, load pointer and both sizes.
    logic [VALUE_W-1:0]     matrix_copy [STORE_DEPTH];
    int                     next_slot = 0;
    logic [DIM_W-1:0]       row_count_reg = DIM_RESET;
    logic [DIM_W-1:0]       column_count_reg = DIM_RESET;

    spiral_result_t         spiral_order [$];       // results of the latest element
    spiral_result_t         pending_spiral [$];     // results still owed by the block

    int                     src_idle_pct = 0;
    int                     sink_stall_pct = 0;
    bit                     sink_hold = 1'b0;

    int                     error_count = 0;
    int                     elements_in = 0;
    int                     results_checked = 0;
    int                     register_writes = 0;
    int                     cycle_count = 0;

    directed_row_t          directed_rows [DIRECTED_ROWS];

    spiral_order_matrix_reader_unit #(
        .MAX_DIM    (DIM_MAX),
        .DATA_WIDTH (VALUE_W)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Size actually in use: zero counts as one, anything above the max as the max.
    function automatic int dim_in_use(input logic [DIM_W-1:0] raw);
        int d;
        if (raw == '0)
            d = 1;
        else if (int'(raw) > DIM_MAX)
            d = DIM_MAX;
        else
            d = int'(raw);
        return d;
    endfunction

    function automatic void queue_position(input int r, input int c, input int cols);
        spiral_result_t res;
        res.value  = matrix_copy[SLOT_W'((r * cols + c) % STORE_DEPTH)];
        res.row    = r[POS_W-1:0];
        res.column = c[POS_W-1:0];
        res.last   = 1'b0;
        spiral_order.push_back(res);
    endfunction

    // Store one element; on the last element of the matrix, walk the rings
    // from the outside in and queue every position in clockwise order.
    function automatic void take_element(input logic [VALUE_W-1:0] value);
        int rows;
        int cols;
        int total;
        int ring;
        int ex;
        int ey;
        int i;
        rows  = dim_in_use(row_count_reg);
        cols  = dim_in_use(column_count_reg);
        total = rows * cols;
        spiral_order.delete();
        // A shrunk size restarts the load at the first element.
        if (next_slot >= total)
            next_slot = 0;
        matrix_copy[SLOT_W'(next_slot % STORE_DEPTH)] = value;
        if (next_slot + 1 < total) begin
            next_slot = (next_slot + 1) % STORE_DEPTH;
            return;
        end
        next_slot = 0;
        ring = 0;
        while (rows > 2 * ring && cols > 2 * ring) begin
            ex = cols - 1 - ring;
            ey = rows - 1 - ring;
            for (i = ring; i <= ex; i++)
                queue_position(ring, i, cols);
            if (ring < ey)
                for (i = ring + 1; i <= ey; i++)
                    queue_position(i, ex, cols);
            // Skip the bottom and left edges when the ring is one row or column.
            if (ring < ex && ring < ey)
                for (i = ex - 1; i >= ring; i--)
                    queue_position(ey, i, cols);
            if (ring < ex && ring + 1 < ey)
                for (i = ey - 1; i >= ring + 1; i--)
                    queue_position(i, ring, cols);
            ring++;
        end
        if (spiral_order.size() > 0)
            spiral_order[spiral_order.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                   input logic [VALUE_W-1:0] got);
        $display("MISMATCH at result %0d, %s: expected %h, got %h",
                 results_checked, what, want, got);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: every transfer is sampled at the rising edge, before the
    // block's own updates of that edge take effect.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        spiral_result_t want;
        spiral_result_t got;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ROW_COUNT:    row_count_reg = cfg_data;
                    REG_COLUMN_COUNT: column_count_reg = cfg_data;
                    default: ;
                endcase
                register_writes++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_element(s_axis_tdata);
                elements_in++;
                // A typed row replaces the predicted result with its own.
                if (item_typed)
                    pending_spiral.push_back(item_typed_result);
                else
                    foreach (spiral_order[k])
                        pending_spiral.push_back(spiral_order[k]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.value  = m_axis_tdata[VALUE_W-1:0];
                got.row    = m_axis_tdata[VALUE_W +: POS_W];
                got.column = m_axis_tdata[VALUE_W + POS_W +: POS_W];
                got.last   = m_axis_tlast;
                if (pending_spiral.size() == 0) begin
                    report_mismatch("unexpected result", '0, got.value);
                end
                else begin
                    want = pending_spiral.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("out_value", want.value, got.value);
                    if (got.row !== want.row)
                        report_mismatch("out_row", VALUE_W'(want.row), VALUE_W'(got.row));
                    if (got.column !== want.column)
                        report_mismatch("out_column", VALUE_W'(want.column),
                                        VALUE_W'(got.column));
                    if (got.last !== want.last)
                        report_mismatch("final_flag", VALUE_W'(want.last),
                                        VALUE_W'(got.last));
                end
                results_checked++;
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results still owed",
                     cycle_count, pending_spiral.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: stall at random, and hold off entirely while sink_hold is set.
    always @(negedge clk)
        m_axis_tready <= !sink_hold && ($urandom_range(0, 99) >= sink_stall_pct);

    // ------------------------------------------------------------------
    // Drivers: entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Offer one element, with random idle cycles in front; leave tvalid high
    // so the next element can follow without a gap.
    task automatic push_element(input logic [VALUE_W-1:0] value, input logic typed,
                                input spiral_result_t typed_result);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid     <= 1'b1;
        s_axis_tdata      <= value;
        item_typed        <= typed;
        item_typed_result <= typed_result;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register once the block has drained and settled.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [DIM_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_spiral.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] random_element();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'h0000_0000;
            3:       v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Mostly small shapes; now and then any 4-bit code, out of range included.
    function automatic logic [DIM_W-1:0] random_dim();
        logic [DIM_W-1:0] d;
        if ($urandom_range(0, 7) == 0)
            d = DIM_W'($urandom_range(0, 15));
        else
            d = DIM_W'($urandom_range(1, 5));
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [DIM_W-1:0] rows_raw;
        logic [DIM_W-1:0] cols_raw;
        int               phase;
        int               phase_items;
        int               matrix_size;

        // Directed table. Typed results are the single-element matrices, whose
        // only result is the element itself at (0, 0) with final_flag set.
        directed_rows = '{
            // partial load at the reset size of 4x4
            '{ROW_ELEM, '0, '0, 32'h0000_0000, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'hFFFF_FFFF, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'h7FFF_FFFF, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'h8000_0000, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'h5555_AAAA, 1'b0, '0},
            // zero sizes count as one; the shrink restarts the load
            '{ROW_CFG, REG_ROW_COUNT, 4'd0, '0, 1'b0, '0},
            '{ROW_CFG, REG_COLUMN_COUNT, 4'd0, '0, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'h7FFF_FFFF, 1'b1, {32'h7FFF_FFFF, 3'd0, 3'd0, 1'b1}},
            // a write to no register changes nothing
            '{ROW_CFG, REG_UNUSED, 4'hF, '0, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'h8000_0000, 1'b1, {32'h8000_0000, 3'd0, 3'd0, 1'b1}},
            '{ROW_ELEM, '0, '0, 32'hFFFF_FFFF, 1'b1, {32'hFFFF_FFFF, 3'd0, 3'd0, 1'b1}},
            // single-row ring
            '{ROW_CFG, REG_COLUMN_COUNT, 4'd3, '0, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'h0000_0001, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'hFFFF_FFFE, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'h1234_5678, 1'b0, '0},
            // single-column ring
            '{ROW_CFG, REG_ROW_COUNT, 4'd3, '0, 1'b0, '0},
            '{ROW_CFG, REG_COLUMN_COUNT, 4'd1, '0, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'hDEAD_BEEF, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'h0F0F_0F0F, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'hF0F0_F0F0, 1'b0, '0},
            // grow the size mid-load: the load carries on where it stood
            '{ROW_ELEM, '0, '0, 32'hAAAA_5555, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'h3333_CCCC, 1'b0, '0},
            '{ROW_CFG, REG_COLUMN_COUNT, 4'd2, '0, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'hCCCC_3333, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'h8000_0001, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'h7FFF_FFFE, 1'b0, '0},
            '{ROW_ELEM, '0, '0, 32'h0000_8000, 1'b0, '0}
        };

        // Hold reset, then release it at a falling edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG)
                write_register(directed_rows[k].reg_index, directed_rows[k].reg_value);
            else
                push_element(directed_rows[k].value, directed_rows[k].typed,
                             directed_rows[k].typed_result);
        end

        // Random phases: complete matrices only, so the spiral never reads an
        // entry that this matrix did not write.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       begin rows_raw = 4'd8;  cols_raw = 4'd8; end
                1:       begin rows_raw = 4'd15; cols_raw = 4'd2; end
                2:       begin rows_raw = 4'd0;  cols_raw = 4'd9; end
                default: begin rows_raw = random_dim(); cols_raw = random_dim(); end
            endcase
            write_register(REG_ROW_COUNT, rows_raw);
            write_register(REG_COLUMN_COUNT, cols_raw);
            matrix_size = dim_in_use(rows_raw) * dim_in_use(cols_raw);

            // Cycle through: no idling, idle sender, stalling receiver, both.
            case (phase % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 75; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 75; end
                default: begin src_idle_pct = 19; sink_stall_pct = 19; end
            endcase

            // Block the output for a long stretch while elements keep coming,
            // so the readout backs up into the input side.
            if (phase == PRESSURE_PHASE)
                fork
                    begin
                        @(posedge clk);
                        sink_hold = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        sink_hold = 1'b0;
                    end
                join_none

            phase_items = 0;
            while (phase_items < PHASE_ITEMS || phase_items % matrix_size != 0) begin
                push_element(random_element(), 1'b0, '0);
                phase_items++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray result.
        while (pending_spiral.size() != 0)
            @(negedge clk);
        repeat (4 * SETTLE_CYCLES) @(negedge clk);

        $display("Summary: %0d elements loaded, %0d spiral results checked",
                 elements_in, results_checked);
        $display("Summary: %0d register writes, shapes 1x1 to 8x8 with idle and stall mixes",
                 register_writes);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
